/* sv/mlfh_pkg.sv */
// ----------------------------------------------------------------------------
// mlfh_pkg
// Shared types and constants for the mutex lock with FIFO hand-off.
// ----------------------------------------------------------------------------
package mlfh_pkg;

  localparam int WAIT_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF    = 8;
  localparam int THREAD_W       = 8;
  localparam int STATUS_W       = 3;

  typedef enum logic [0:0] {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } mlfh_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_FREED     = 3'd3,
    ST_HANDOVER  = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6
  } mlfh_status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } mlfh_qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mlfh_qsts_t;

endpackage

/* sv/mlfh_queue.sv */
// ----------------------------------------------------------------------------
// mlfh_queue
// Waiter FIFO: memory, head/tail pointers, fill count and a head register
// that always holds the entry at the head of the queue.
// ----------------------------------------------------------------------------
module mlfh_queue
  import mlfh_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int ID_W       = ID_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  mlfh_qctl_t      qctl,
  input  logic [ID_W-1:0] wdata,
  output mlfh_qsts_t      qsts,
  output logic [ID_W-1:0] head_data
);

  localparam int PtrW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CntW = $clog2(WAIT_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(WAIT_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(WAIT_DEPTH);

  logic [ID_W-1:0] mem [WAIT_DEPTH];
  logic [PtrW-1:0] head, head_next, head_inc;
  logic [PtrW-1:0] tail, tail_next, tail_inc;
  logic [CntW-1:0] count, count_next;

  always_comb begin
    head_inc   = (head == PtrLast) ? '0 : head + 1'b1;
    tail_inc   = (tail == PtrLast) ? '0 : tail + 1'b1;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (qctl.push) begin
      tail_next  = tail_inc;
      count_next = count + 1'b1;
    end else if (qctl.pop) begin
      head_next  = head_inc;
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // hold the head entry in a register; load it from the next slot on a pop, or on a push into an empty queue
  always_ff @(posedge clk) begin
    if (qctl.push) begin
      mem[tail] <= wdata;
    end
    if (qctl.pop) begin
      head_data <= mem[head_inc];
    end else if (qctl.push && qsts.empty) begin
      head_data <= wdata;
    end
  end

  assign qsts.empty = (count == '0);
  assign qsts.full  = (count == CntFull);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntFull)
    else $error("waiter count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qctl.pop |-> !qsts.empty)
    else $error("pop from empty waiter queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qctl.push |-> !qsts.full)
    else $error("push into full waiter queue");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(qctl.push && qctl.pop))
    else $error("push and pop in one transfer");

endmodule

/* sv/mlfh_lock.sv */
// ----------------------------------------------------------------------------
// mlfh_lock
// Owner and busy registers with the per-request decision logic.
// ----------------------------------------------------------------------------
module mlfh_lock
  import mlfh_pkg::*;
#(
  parameter int ID_W = ID_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  mlfh_req_t       req,
  input  logic [ID_W-1:0] tid,
  input  mlfh_qsts_t      qsts,
  input  logic [ID_W-1:0] head_data,
  output mlfh_qctl_t      qctl,
  output mlfh_status_t    status_next,
  output logic            woken_valid_next,
  output logic [ID_W-1:0] woken_thread_next,
  output logic            lock_busy_next
);

  logic            busy_flag, busy_flag_next;
  logic [ID_W-1:0] owner, owner_next;
  logic            is_owner;

  always_comb begin
    is_owner          = busy_flag && (owner == tid);
    busy_flag_next    = busy_flag;
    owner_next        = owner;
    qctl              = '0;
    status_next       = ST_NOT_OWNER;
    woken_valid_next  = 1'b0;
    woken_thread_next = '0;
    if (req == REQ_ACQUIRE) begin
      if (is_owner) begin
        status_next = ST_ALREADY;
      end else if (!busy_flag) begin
        busy_flag_next = 1'b1;
        owner_next     = tid;
        status_next    = ST_GRANTED;
      end else if (qsts.full) begin
        status_next = ST_FULL;
      end else begin
        qctl.push   = req_valid;
        status_next = ST_QUEUED;
      end
    end else begin
      if (!is_owner) begin
        status_next = ST_NOT_OWNER;
      end else if (qsts.empty) begin
        busy_flag_next = 1'b0;
        owner_next     = '0;
        status_next    = ST_FREED;
      end else begin
        qctl.pop          = req_valid;
        owner_next        = head_data;
        woken_valid_next  = 1'b1;
        woken_thread_next = head_data;
        status_next       = ST_HANDOVER;
      end
    end
    lock_busy_next = busy_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag <= 1'b0;
      owner     <= '0;
    end else if (req_valid) begin
      busy_flag <= busy_flag_next;
      owner     <= owner_next;
    end
  end

endmodule

/* sv/mutex_lock_fifo_handoff_top.sv */
// ----------------------------------------------------------------------------
// mutex_lock_fifo_handoff_top
// Hardware mutex with a FIFO of waiting threads and direct hand-off.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------
//   request  | start / busy     | req_type, thread_id
//   result   | done (strobe)    | status, woken_valid, woken_thread, lock_busy
//
// One request is taken per cycle; its result strobes on done the next cycle.
// Each result is captured by the result register after the decision
// logic; the head waiter sits in a register so hand-off needs no memory wait.
// busy is high only while rst is asserted; reset clears lock, pointers, count.
// The receiver cannot stall: each result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module mutex_lock_fifo_handoff_top
  import mlfh_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [THREAD_W-1:0] thread_id,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                woken_valid,
  output logic [THREAD_W-1:0] woken_thread,
  output logic                lock_busy
);

  localparam int IdW = (ID_BITS < THREAD_W) ? ID_BITS : THREAD_W;

  logic            req_valid;
  logic [IdW-1:0]  tid;
  mlfh_qctl_t      qctl;
  mlfh_qsts_t      qsts;
  logic [IdW-1:0]  head_data;
  mlfh_status_t    status_next;
  logic            woken_valid_next;
  logic [IdW-1:0]  woken_thread_next;
  logic            lock_busy_next;

  assign busy      = rst;
  assign req_valid = start && !busy;
  assign tid       = thread_id[IdW-1:0];

  mlfh_lock #(
    .ID_W (IdW)
  ) u_lock (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req               (mlfh_req_t'(req_type)),
    .tid               (tid),
    .qsts              (qsts),
    .head_data         (head_data),
    .qctl              (qctl),
    .status_next       (status_next),
    .woken_valid_next  (woken_valid_next),
    .woken_thread_next (woken_thread_next),
    .lock_busy_next    (lock_busy_next)
  );

  mlfh_queue #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .ID_W       (IdW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .qctl      (qctl),
    .wdata     (tid),
    .qsts      (qsts),
    .head_data (head_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      status       <= status_next;
      woken_valid  <= woken_valid_next;
      woken_thread <= THREAD_W'(woken_thread_next);
      lock_busy    <= lock_busy_next;
    end
  end

  a_handover_woken: assert property (@(posedge clk) disable iff (rst)
    done |-> (woken_valid == (status == ST_HANDOVER)))
    else $error("woken flag disagrees with status");

  a_busy_after_grant: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_GRANTED || status == ST_HANDOVER || status == ST_QUEUED
             || status == ST_ALREADY) |-> lock_busy)
    else $error("lock free after grant, hand-off or queueing");

  a_free_after_release: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FREED) |-> !lock_busy)
    else $error("lock still held after free");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hardware mutex with FIFO hand-off: a queue-fed
// driver issues acquire and release requests (many of them by the current
// owner, so that hand-offs and frees happen often), a clocked monitor predicts
// every result and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfh_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [THREAD_W-1:0] ID_MASK = THREAD_W'((1 << ID_BITS_DEF) - 1);

  typedef enum logic [1:0] {
    SLOT_REQ,
    SLOT_IDLE,
    SLOT_DRAIN
  } slot_kind_t;

  typedef struct {
    slot_kind_t          kind;
    mlfh_req_t           req;
    logic [THREAD_W-1:0] tid;
    bit                  by_holder;
  } req_slot_t;

  typedef struct {
    mlfh_status_t        status;
    bit                  woken_valid;
    logic [THREAD_W-1:0] woken_thread;
    bit                  lock_busy;
  } lock_res_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                req_type;
  logic [THREAD_W-1:0] thread_id;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                woken_valid;
  logic [THREAD_W-1:0] woken_thread;
  logic                lock_busy;

  req_slot_t           pending_reqs[$];
  lock_res_t           awaited_results[$];
  req_slot_t           drv_slot;
  lock_res_t           got_res;

  bit                  held;
  logic [THREAD_W-1:0] holder;
  logic [THREAD_W-1:0] waiters[$];

  bit                  took;
  int                  idle_pct;
  int                  reqs_queued;
  int                  reqs_taken;
  int                  fails;
  int                  cycles;
  int                  status_hits[7];
  logic [THREAD_W-1:0] id_pool[4];

  mutex_lock_fifo_handoff_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .thread_id    (thread_id),
    .done         (done),
    .status       (status),
    .woken_valid  (woken_valid),
    .woken_thread (woken_thread),
    .lock_busy    (lock_busy)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic lock_res_t lock_outcome(mlfh_req_t req, logic [THREAD_W-1:0] tid_in);
    lock_res_t           r;
    logic [THREAD_W-1:0] tid;
    bit                  mine;
    tid            = tid_in & ID_MASK;
    mine           = held && (holder == tid);
    r.woken_valid  = 1'b0;
    r.woken_thread = '0;
    if (req == REQ_ACQUIRE) begin
      if (mine) begin
        r.status = ST_ALREADY;
      end else if (!held) begin
        held     = 1'b1;
        holder   = tid;
        r.status = ST_GRANTED;
      end else if (waiters.size() >= WAIT_DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        waiters.push_back(tid);
        r.status = ST_QUEUED;
      end
    end else begin
      if (!mine) begin
        r.status = ST_NOT_OWNER;
      end else if (waiters.size() == 0) begin
        held     = 1'b0;
        holder   = '0;
        r.status = ST_FREED;
      end else begin
        r.woken_thread = waiters.pop_front() & ID_MASK;
        r.woken_valid  = 1'b1;
        holder         = r.woken_thread;
        r.status       = ST_HANDOVER;
      end
    end
    r.lock_busy = held;
    return r;
  endfunction

  task automatic add_req(mlfh_req_t req, logic [THREAD_W-1:0] tid, bit by_holder);
    req_slot_t s;
    s.req       = req;
    s.tid       = '0;
    s.by_holder = 1'b0;
    s.kind      = SLOT_IDLE;
    while ($urandom_range(99) < idle_pct) pending_reqs.push_back(s);
    s.kind      = SLOT_REQ;
    s.tid       = tid;
    s.by_holder = by_holder;
    pending_reqs.push_back(s);
    reqs_queued++;
  endtask

  task automatic add_drain();
    req_slot_t s;
    s.kind      = SLOT_DRAIN;
    s.req       = REQ_ACQUIRE;
    s.tid       = '0;
    s.by_holder = 1'b0;
    pending_reqs.push_back(s);
  endtask

  task automatic check_field(string name, int unsigned want, logic [7:0] got);
    if (got !== 8'(want)) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // driver: present the next request once the previous transfer is done
  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else begin
        case (pending_reqs[0].kind)
          SLOT_IDLE: begin
            drv_slot = pending_reqs.pop_front();
            start <= 1'b0;
          end
          SLOT_DRAIN: begin
            start <= 1'b0;
            if (awaited_results.size() == 0) drv_slot = pending_reqs.pop_front();
          end
          default: begin
            drv_slot = pending_reqs.pop_front();
            start     <= 1'b1;
            req_type  <= drv_slot.req;
            thread_id <= drv_slot.by_holder ? holder : drv_slot.tid;
          end
        endcase
      end
    end
  end

  // monitor: predict on each request transfer, check each strobed result
  always @(posedge clk) begin
    if (rst) begin
      took = 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        awaited_results.push_back(lock_outcome(mlfh_req_t'(req_type), thread_id));
        reqs_taken++;
      end
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result strobed with no request outstanding");
          fails++;
        end else begin
          got_res = awaited_results.pop_front();
          status_hits[got_res.status]++;
          check_field("status", got_res.status, 8'(status));
          check_field("woken_valid", got_res.woken_valid, 8'(woken_valid));
          check_field("woken_thread", got_res.woken_thread, woken_thread);
          check_field("lock_busy", got_res.lock_busy, 8'(lock_busy));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mutex_lock_fifo_handoff_top verification failed");
      $finish;
    end
  end

  initial begin
    int r;
    int target;
    rst       = 1'b1;
    start     = 1'b0;
    req_type  = 1'b0;
    thread_id = '0;
    held      = 1'b0;
    holder    = '0;
    idle_pct  = 0;

    id_pool = '{8'hFF, 8'h5A, 8'hA5, 8'h3C};
    add_req(REQ_RELEASE, 8'h00, 1'b0);
    add_req(REQ_ACQUIRE, 8'h00, 1'b0);
    add_req(REQ_ACQUIRE, 8'h00, 1'b0);
    add_req(REQ_RELEASE, 8'hFF, 1'b0);
    add_req(REQ_ACQUIRE, 8'hFF, 1'b0);
    add_req(REQ_ACQUIRE, 8'hFF, 1'b0);
    for (int i = 0; i < WAIT_DEPTH_DEF - 2; i++) add_req(REQ_ACQUIRE, id_pool[i % 4], 1'b0);
    add_req(REQ_ACQUIRE, 8'h3C, 1'b0);
    add_req(REQ_RELEASE, 8'h00, 1'b0);
    add_req(REQ_RELEASE, 8'hFF, 1'b0);
    add_drain();

    foreach (id_pool[p]) begin
      if (p == 3) break;
      idle_pct = (p == 0) ? 0 : (p == 1) ? 75 : 10;
      foreach (id_pool[k]) id_pool[k] = THREAD_W'($urandom_range(255));
      target = reqs_queued + 160;
      while (reqs_queued < target) begin
        r = $urandom_range(99);
        if (r < 3) begin
          repeat (WAIT_DEPTH_DEF + 2) add_req(REQ_ACQUIRE, id_pool[$urandom_range(3)], 1'b0);
        end else if (r < 6) begin
          repeat (WAIT_DEPTH_DEF + 2) add_req(REQ_RELEASE, '0, 1'b1);
        end else if (r < 38) begin
          add_req(REQ_RELEASE, '0, 1'b1);
        end else if (r < 66) begin
          add_req(REQ_ACQUIRE, id_pool[$urandom_range(3)], 1'b0);
        end else if (r < 75) begin
          add_req(REQ_ACQUIRE, '0, 1'b1);
        end else if (r < 86) begin
          add_req(REQ_RELEASE, THREAD_W'($urandom_range(255)), 1'b0);
        end else begin
          add_req(REQ_ACQUIRE, THREAD_W'($urandom_range(255)), 1'b0);
        end
      end
      add_drain();
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    while (reqs_taken < reqs_queued || awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests checked over no-idle, heavy-idle and light-idle phases",
             reqs_taken);
    $display("granted %0d, already %0d, queued %0d, freed %0d, handed %0d, refused %0d, full %0d",
             status_hits[ST_GRANTED], status_hits[ST_ALREADY], status_hits[ST_QUEUED],
             status_hits[ST_FREED], status_hits[ST_HANDOVER], status_hits[ST_NOT_OWNER],
             status_hits[ST_FULL]);
    if (fails == 0) begin
      $display("mutex_lock_fifo_handoff_top verification clean");
    end else begin
      $display("mutex_lock_fifo_handoff_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mlfh_pkg.sv
sv/mlfh_queue.sv
sv/mlfh_lock.sv
sv/mutex_lock_fifo_handoff_top.sv
tb/testbench.sv
